>>> rtl/core/brightness_histogram_valley_finder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the brightness histogram valley finder
// Clocked concurrent assertion wrappers, included by the histogram store.
// ----------------------------------------------------------------------------
`ifndef BRIGHTNESS_HISTOGRAM_VALLEY_FINDER_ASSERT_SVH
`define BRIGHTNESS_HISTOGRAM_VALLEY_FINDER_ASSERT_SVH

// checked outside reset only
`define BHVF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define BHVF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/bhvf_pkg.sv
// ----------------------------------------------------------------------------
// Brightness histogram valley finder package
// Widths, item kinds and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package bhvf_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int NUM_BINS    = 256;
   localparam int BIN_WIDTH   = 8;
   localparam int OUT_WIDTH   = 24;
   localparam int COLOR_WIDTH = 8;
   localparam int KIND_WIDTH  = 2;
   localparam int REQ_WIDTH   = 32;
   localparam int RSP_WIDTH   = 32;

   // floor(s / 3) == (s * 683) >> 11 for every s up to 3 * 255
   localparam int SUM_WIDTH   = 10;
   localparam int DIV3_MUL    = 683;
   localparam int DIV3_SHIFT  = 11;
   localparam int PROD_WIDTH  = 20;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [BIN_WIDTH-1:0]   bin_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PIXEL = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      bin_type  bin;
   } issue_type;

   typedef struct packed {
      logic                 valid;
      logic [OUT_WIDTH-1:0] count;
      logic                 valley;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/bhvf_front.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers the accepted item and works out the bin it addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module bhvf_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 req_tvalid,
   input  logic [bhvf_pkg::REQ_WIDTH-1:0]       req_tdata,
   input  logic [bhvf_pkg::KIND_WIDTH-1:0]      req_tuser,
   output bhvf_pkg::issue_type                  issue
);
   import bhvf_pkg::*;

   logic                   a_valid_ff, a_valid_in;
   logic [KIND_WIDTH-1:0]  a_kind_ff, a_kind_in;
   logic [COLOR_WIDTH-1:0] a_red_ff, a_red_in;
   logic [COLOR_WIDTH-1:0] a_green_ff, a_green_in;
   logic [COLOR_WIDTH-1:0] a_blue_ff, a_blue_in;
   bin_type                a_index_ff, a_index_in;

   logic [SUM_WIDTH-1:0]   sum;
   logic [PROD_WIDTH-1:0]  prod;
   bin_type                bright;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_kind_in  = a_kind_ff;
      a_red_in   = a_red_ff;
      a_green_in = a_green_ff;
      a_blue_in  = a_blue_ff;
      a_index_in = a_index_ff;
      if (advance) begin
         a_valid_in = req_tvalid;
         a_kind_in  = req_tuser;
         a_red_in   = req_tdata[0 +: COLOR_WIDTH];
         a_green_in = req_tdata[COLOR_WIDTH +: COLOR_WIDTH];
         a_blue_in  = req_tdata[2*COLOR_WIDTH +: COLOR_WIDTH];
         a_index_in = req_tdata[3*COLOR_WIDTH +: BIN_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_kind_ff  <= a_kind_in;
      a_red_ff   <= a_red_in;
      a_green_ff <= a_green_in;
      a_blue_ff  <= a_blue_in;
      a_index_ff <= a_index_in;
   end

   // brightness = floor((r + g + b) / 3) by reciprocal multiply
   always_comb begin
      sum    = SUM_WIDTH'(a_red_ff) + SUM_WIDTH'(a_green_ff) + SUM_WIDTH'(a_blue_ff);
      prod   = PROD_WIDTH'(sum) * PROD_WIDTH'(DIV3_MUL);
      bright = prod[DIV3_SHIFT +: BIN_WIDTH];
   end

   always_comb begin
      issue.valid = a_valid_ff;
      issue.kind  = kind_type'(a_kind_ff);
      case (kind_type'(a_kind_ff))
         KIND_PIXEL: issue.bin = bright;
         KIND_QUERY: issue.bin = a_index_ff;
         default:    issue.bin = a_index_ff;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/bhvf_store.sv
// ----------------------------------------------------------------------------
// Histogram store
// Banked bin counters, read-modify-write update and the valley test.
// ----------------------------------------------------------------------------
`default_nettype none

module bhvf_store (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bhvf_pkg::issue_type    issue,
   output bhvf_pkg::result_type   result
);
   import bhvf_pkg::*;

   `include "brightness_histogram_valley_finder_assert.svh"

   localparam int HALF_DEPTH = NUM_BINS / 2;
   localparam int HALF_AW    = BIN_WIDTH - 1;
   localparam int SAT_WIDTH  = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;
   localparam count_type COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [OUT_WIDTH-1:0] OUT_MAX = {OUT_WIDTH{1'b1}};
   localparam bin_type LAST_BIN = BIN_WIDTH'(NUM_BINS - 1);

   // even bins in one bank, odd bins in the other: a bin and its two
   // neighbors need at most two reads from either bank
   count_type even_mem [HALF_DEPTH];
   count_type odd_mem  [HALF_DEPTH];

   count_type even_q0_ff, even_q1_ff, odd_q0_ff, odd_q1_ff;

   logic [HALF_AW-1:0] even_addr0, odd_addr0, right_addr, wr_addr;
   bin_type            a_left, a_right;

   logic               b_valid_ff, b_valid_in;
   kind_type           b_kind_ff, b_kind_in;
   bin_type            b_bin_ff, b_bin_in;

   logic               fwd_valid_ff, fwd_valid_in;
   bin_type            fwd_bin_ff, fwd_bin_in;
   count_type          fwd_data_ff, fwd_data_in;

   logic [NUM_BINS-1:0] bin_valid_ff, bin_valid_in;

   bin_type            b_left, b_right;
   count_type          center_raw, left_raw, right_raw;
   count_type          center_cnt, left_cnt, right_cnt;
   count_type          inc_cnt;
   logic               wr_en, clr_en;
   logic               left_ok, right_ok;

   function automatic count_type resolve(input logic valid, input logic hit,
                                         input count_type fwd, input count_type raw);
      count_type v;
      if (!valid) begin
         v = '0;
      end else if (hit) begin
         v = fwd;
      end else begin
         v = raw;
      end
      return v;
   endfunction

   function automatic logic [OUT_WIDTH-1:0] sat_out(input count_type c);
      logic [SAT_WIDTH-1:0] w;
      logic [OUT_WIDTH-1:0] r;
      w = SAT_WIDTH'(c);
      if (w > SAT_WIDTH'(OUT_MAX)) begin
         r = OUT_MAX;
      end else begin
         r = w[OUT_WIDTH-1:0];
      end
      return r;
   endfunction

   // read addresses from the input stage
   always_comb begin
      a_left     = issue.bin - BIN_WIDTH'(1);
      a_right    = issue.bin + BIN_WIDTH'(1);
      right_addr = a_right[BIN_WIDTH-1:1];
      if (issue.bin[0]) begin
         even_addr0 = a_left[BIN_WIDTH-1:1];
         odd_addr0  = issue.bin[BIN_WIDTH-1:1];
      end else begin
         even_addr0 = issue.bin[BIN_WIDTH-1:1];
         odd_addr0  = a_left[BIN_WIDTH-1:1];
      end
   end

   // stage B: pick words, apply valid flags and the bypass of the last write
   always_comb begin
      b_left  = b_bin_ff - BIN_WIDTH'(1);
      b_right = b_bin_ff + BIN_WIDTH'(1);
      if (b_bin_ff[0]) begin
         center_raw = odd_q0_ff;
         left_raw   = even_q0_ff;
         right_raw  = even_q1_ff;
      end else begin
         center_raw = even_q0_ff;
         left_raw   = odd_q0_ff;
         right_raw  = odd_q1_ff;
      end
      center_cnt = resolve(bin_valid_ff[b_bin_ff], fwd_valid_ff && (fwd_bin_ff == b_bin_ff),
                           fwd_data_ff, center_raw);
      left_cnt   = resolve(bin_valid_ff[b_left], fwd_valid_ff && (fwd_bin_ff == b_left),
                           fwd_data_ff, left_raw);
      right_cnt  = resolve(bin_valid_ff[b_right], fwd_valid_ff && (fwd_bin_ff == b_right),
                           fwd_data_ff, right_raw);

      inc_cnt  = (center_cnt == COUNT_MAX) ? center_cnt : center_cnt + COUNT_WIDTH'(1);
      wr_en    = advance && b_valid_ff && (b_kind_ff == KIND_PIXEL);
      clr_en   = advance && b_valid_ff && (b_kind_ff == KIND_CLEAR);
      wr_addr  = b_bin_ff[BIN_WIDTH-1:1];

      right_ok = (b_bin_ff == LAST_BIN) || (right_cnt > center_cnt);
      left_ok  = (b_bin_ff == '0) || (left_cnt >= center_cnt);

      result.valid  = b_valid_ff && (b_kind_ff == KIND_QUERY);
      result.count  = sat_out(center_cnt);
      result.valley = left_ok && right_ok;
   end

   always_ff @(posedge clock) begin
      if (wr_en && !b_bin_ff[0]) begin
         even_mem[wr_addr] <= inc_cnt;
      end
      if (advance) begin
         even_q0_ff <= even_mem[even_addr0];
         even_q1_ff <= even_mem[right_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && b_bin_ff[0]) begin
         odd_mem[wr_addr] <= inc_cnt;
      end
      if (advance) begin
         odd_q0_ff <= odd_mem[odd_addr0];
         odd_q1_ff <= odd_mem[right_addr];
      end
   end

   always_comb begin
      b_valid_in   = b_valid_ff;
      b_kind_in    = b_kind_ff;
      b_bin_in     = b_bin_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_bin_in   = fwd_bin_ff;
      fwd_data_in  = fwd_data_ff;
      bin_valid_in = bin_valid_ff;
      if (advance) begin
         b_valid_in   = issue.valid;
         b_kind_in    = issue.kind;
         b_bin_in     = issue.bin;
         fwd_valid_in = wr_en;
         fwd_bin_in   = b_bin_ff;
         fwd_data_in  = inc_cnt;
      end
      if (clr_en) begin
         bin_valid_in = '0;
      end else if (wr_en) begin
         bin_valid_in[b_bin_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         bin_valid_ff <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         bin_valid_ff <= bin_valid_in;
      end
      b_kind_ff   <= b_kind_in;
      b_bin_ff    <= b_bin_in;
      fwd_bin_ff  <= fwd_bin_in;
      fwd_data_ff <= fwd_data_in;
   end

   `BHVF_ASSERT_ALWAYS(a_reset_empties, reset |=> !b_valid_ff && !fwd_valid_ff, "stage B not empty after reset")
   `BHVF_ASSERT(a_stall_holds, !advance |=> $stable(b_valid_ff) && $stable(b_bin_ff) && $stable(b_kind_ff), "stage B moved during stall")
   `BHVF_ASSERT(a_write_marks, wr_en |=> bin_valid_ff[$past(b_bin_ff)] && fwd_valid_ff, "written bin not marked valid")
   `BHVF_ASSERT(a_written_nonzero, fwd_valid_ff |-> fwd_data_ff != '0, "counter update wrapped to zero")

endmodule

`default_nettype wire

>>> rtl/core/brightness_histogram_valley_finder.sv
// ----------------------------------------------------------------------------
// Brightness histogram valley finder
// 256-bin brightness histogram with per-bin count and local minimum query.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries items: tuser = kind (pixel, query, clear); tdata holds
//   red, green, blue and the bin to query. A pixel adds one to bin
//   floor((r+g+b)/3), saturating; a clear empties the histogram; neither
//   gives a result. Kind 3 is ignored.
//   A query returns one rsp item: the bin count (saturated to 24 bits) and a
//   valley flag (right neighbor strictly larger, left neighbor not smaller,
//   missing neighbors at the ends skipped).
//   Throughput: one item per cycle while rsp is not stalled, set by the banked bin
//   memory (even/odd banks with two read ports each) and its read-modify-write
//   with bypass of the previous update.
//   A query result reaches rsp through the input register, the memory read
//   register and the result register, in that order.
//   Reset: the histogram reads as empty at once (per-bin valid flags); no
//   clearing pass, items are taken as soon as reset is released.
//   Stall: while a result waits on rsp, the whole pipeline holds and
//   req_tready drops; no item is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module brightness_histogram_valley_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] bin_index
   input  logic [bhvf_pkg::REQ_WIDTH-1:0]    req_tdata,
   // [1:0] kind
   input  logic [bhvf_pkg::KIND_WIDTH-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] bin_count, [24] is_valley, [31:25] zero
   output logic [bhvf_pkg::RSP_WIDTH-1:0]    rsp_tdata
);
   import bhvf_pkg::*;

   logic                 advance;
   issue_type            issue;
   result_type           result;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                 rsp_valley_ff, rsp_valley_in;

   // pipeline moves unless a result is waiting
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   bhvf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .issue      (issue)
   );

   bhvf_store u_store (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .issue   (issue),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valley_in = rsp_valley_ff;
      if (advance) begin
         rsp_valid_in  = result.valid;
         rsp_count_in  = result.count;
         rsp_valley_in = result.valley;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff  <= rsp_count_in;
      rsp_valley_ff <= rsp_valley_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_WIDTH - OUT_WIDTH - 1)'(0), rsp_valley_ff, rsp_count_ff};

endmodule

`default_nettype wire
